### src/typesetter_stream_page_splitter_macros.svh
// Assertion macros shared by the page splitter modules.
`ifndef TYPESETTER_STREAM_PAGE_SPLITTER_MACROS_SVH
`define TYPESETTER_STREAM_PAGE_SPLITTER_MACROS_SVH

// The expression holds at every clock edge outside reset.
`define TSPS_ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define TSPS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define TSPS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/tsps_pkg.sv
// Shared types and constants of the typesetter stream page splitter.
`default_nettype none

package tsps_pkg;

    // Code bytes of the phototypesetter stream.
    localparam logic [7:0] CODE_INIT = 8'h40;
    localparam logic [7:0] CODE_STOP = 8'h49;
    localparam logic [7:0] CODE_FILL = 8'h60;
    localparam logic [7:0] CODE_TAIL = 8'h41;
    localparam logic [7:0] CODE_F    = 8'h66;
    localparam logic [7:0] CODE_ZERO = 8'h00;

    // Trailer run lengths and the argument count after a stop code.
    localparam logic [7:0] FILL_RUN  = 8'd65;
    localparam logic [7:0] TAIL_RUN  = 8'd8;
    localparam logic [7:0] SINGLE    = 8'd1;
    localparam logic [3:0] ARG_COUNT = 4'd8;

    // Configuration register indexes and reset values.
    localparam logic REG_PAGE_LIMIT = 1'b0;
    localparam logic REG_SKIP_INITS = 1'b1;
    localparam logic [15:0] PAGE_LIMIT_RST = 16'd100;
    localparam logic [15:0] SKIP_INITS_RST = 16'd0;

    // One input byte causes at most this many runs.
    localparam int MAX_RUNS = 4;

    typedef enum logic [2:0] {
        PH_NORMAL     = 3'd0,
        PH_AFTER_INIT = 3'd1,
        PH_AFTER_STOP = 3'd2,
        PH_ARGS       = 3'd3,
        PH_DONE       = 3'd4
    } phase_t;

    typedef struct packed {
        logic [7:0] value;
        logic [7:0] rep;
    } run_t;

    typedef struct packed {
        run_t [MAX_RUNS-1:0] runs;
        logic [2:0]          cnt;
    } run_list_t;

endpackage

`default_nettype wire

### src/tsps_step.sv
// Input register, stream state machine and run list builder.
`default_nettype none

`include "typesetter_stream_page_splitter_macros.svh"

module tsps_step (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic [7:0]          s_code_byte,
    input  wire logic [15:0]         page_limit,
    input  wire logic [15:0]         skip_inits,
    input  wire logic                list_ready,
    output logic                     list_load,
    output tsps_pkg::run_list_t      list_out
);

    logic                 in_valid_reg;
    logic [7:0]           in_byte_reg;
    tsps_pkg::phase_t     phase_reg, phase_next;
    logic [16:0]          page_reg, page_next;
    logic [15:0]          inits_reg, inits_next;
    logic [3:0]           args_reg, args_next;
    logic                 first_reg, first_next;
    logic [15:0]          inits_inc;
    logic [3:0]           args_dec;
    logic                 sup;
    logic                 sup_after;
    logic                 advance;
    tsps_pkg::run_list_t  list;

    // Append one run to a list.
    function automatic tsps_pkg::run_list_t add_run(
        input tsps_pkg::run_list_t l,
        input logic [7:0]          value,
        input logic [7:0]          rep
    );
        tsps_pkg::run_list_t r;
        r = l;
        r.runs[l.cnt[1:0]].value = value;
        r.runs[l.cnt[1:0]].rep   = rep;
        r.cnt = l.cnt + 3'd1;
        return r;
    endfunction

    // Append the fill, stop and tail runs of a trailer.
    function automatic tsps_pkg::run_list_t add_trailer(input tsps_pkg::run_list_t l);
        tsps_pkg::run_list_t r;
        r = add_run(l, tsps_pkg::CODE_FILL, tsps_pkg::FILL_RUN);
        r = add_run(r, tsps_pkg::CODE_STOP, tsps_pkg::SINGLE);
        r = add_run(r, tsps_pkg::CODE_TAIL, tsps_pkg::TAIL_RUN);
        return r;
    endfunction

    // A held byte moves on when its runs have a place to go.
    assign advance   = in_valid_reg && ((list.cnt == 3'd0) || list_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign list_load = advance && (list.cnt != 3'd0);
    assign list_out  = list;

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            in_byte_reg <= s_code_byte;
        end
    end

    // Stream state registers, updated when a byte is processed.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= tsps_pkg::PH_NORMAL;
            page_reg  <= '0;
            inits_reg <= '0;
            args_reg  <= '0;
            first_reg <= 1'b1;
        end else if (advance) begin
            phase_reg <= phase_next;
            page_reg  <= page_next;
            inits_reg <= inits_next;
            args_reg  <= args_next;
            first_reg <= first_next;
        end
    end

    // Output is withheld until enough init codes have been seen.
    assign inits_inc = inits_reg + 16'd1;
    assign sup       = (skip_inits != 16'd0) && (inits_reg < skip_inits);
    assign sup_after = (skip_inits != 16'd0) && (inits_inc < skip_inits);
    assign args_dec  = (args_reg != 4'd0) ? args_reg - 4'd1 : 4'd0;

    // Next state and the runs caused by the held byte.
    always_comb begin
        phase_next = phase_reg;
        page_next  = page_reg;
        inits_next = inits_reg;
        args_next  = args_reg;
        first_next = first_reg;
        list       = '0;
        case (phase_reg)
            tsps_pkg::PH_NORMAL: begin
                if (!sup) begin
                    list = add_run(list, in_byte_reg, tsps_pkg::SINGLE);
                end
                if (in_byte_reg == tsps_pkg::CODE_INIT) begin
                    if (page_reg > {1'b0, page_limit}) begin
                        page_next = 17'd1;
                        if (!sup) begin
                            list = add_trailer(list);
                        end
                    end else begin
                        page_next = page_reg + 17'd1;
                    end
                    if (sup) begin
                        inits_next = inits_inc;
                        if (!sup_after) begin
                            list = add_run(list, tsps_pkg::CODE_INIT, tsps_pkg::SINGLE);
                        end
                    end
                    phase_next = tsps_pkg::PH_AFTER_INIT;
                end
            end
            tsps_pkg::PH_AFTER_INIT: begin
                if (in_byte_reg == tsps_pkg::CODE_STOP) begin
                    phase_next = tsps_pkg::PH_AFTER_STOP;
                end else begin
                    if (!sup) begin
                        list = add_run(list, in_byte_reg, tsps_pkg::SINGLE);
                    end
                    phase_next = tsps_pkg::PH_NORMAL;
                end
            end
            tsps_pkg::PH_AFTER_STOP: begin
                if (in_byte_reg == tsps_pkg::CODE_F) begin
                    args_next  = tsps_pkg::ARG_COUNT;
                    phase_next = tsps_pkg::PH_ARGS;
                end else if (in_byte_reg == tsps_pkg::CODE_ZERO) begin
                    if (!sup) begin
                        list = add_trailer(list);
                    end
                    phase_next = tsps_pkg::PH_DONE;
                end else begin
                    if (!sup) begin
                        list = add_run(list, in_byte_reg, tsps_pkg::SINGLE);
                    end
                    phase_next = tsps_pkg::PH_NORMAL;
                end
            end
            tsps_pkg::PH_ARGS: begin
                args_next = args_dec;
                if (args_dec == 4'd0) begin
                    if (first_reg && !sup) begin
                        first_next = 1'b0;
                        list = add_run(list, tsps_pkg::CODE_FILL, tsps_pkg::SINGLE);
                    end
                    phase_next = tsps_pkg::PH_NORMAL;
                end
            end
            tsps_pkg::PH_DONE: begin
                phase_next = tsps_pkg::PH_DONE;
            end
            default: begin
                phase_next = tsps_pkg::PH_DONE;
            end
        endcase
    end

    // An ended stream stays ended.
    `TSPS_ASSERT_NEXT(a_done_sticks, aclk, aresetn, phase_reg == tsps_pkg::PH_DONE, phase_reg == tsps_pkg::PH_DONE, "stream left the ended phase")
    // Argument bytes are only counted while skipping arguments.
    `TSPS_ASSERT_IMPL(a_args_phase, aclk, aresetn, args_reg != 4'd0, phase_reg == tsps_pkg::PH_ARGS, "argument count outside argument phase")
    // No byte causes more runs than the list holds.
    `TSPS_ASSERT_ALWAYS(a_list_size, aclk, aresetn, !in_valid_reg || (list.cnt <= 3'd4), "run list overflow")

endmodule

`default_nettype wire

### src/tsps_out.sv
// Result register that hands out a run list one request at a time.
`default_nettype none

`include "typesetter_stream_page_splitter_macros.svh"

module tsps_out (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                list_load,
    input  wire tsps_pkg::run_list_t list_in,
    output logic                     list_ready,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic [7:0]               m_out_byte,
    output logic [7:0]               m_repeat_res,
    output logic                     m_last
);

    tsps_pkg::run_t [tsps_pkg::MAX_RUNS-1:0] runs_reg;
    logic [2:0] cnt_reg;
    logic [1:0] idx_reg;
    logic       at_last;

    assign at_last      = ({1'b0, idx_reg} == (cnt_reg - 3'd1));
    assign m_valid      = (cnt_reg != 3'd0);
    assign m_out_byte   = runs_reg[idx_reg].value;
    assign m_repeat_res = runs_reg[idx_reg].rep;
    assign m_last       = at_last;

    // A new list may enter when the current one is gone or leaves now.
    assign list_ready = (cnt_reg == 3'd0) || (at_last && m_ready);

    // Run list storage and read position.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            idx_reg <= '0;
        end else if (list_load) begin
            cnt_reg <= list_in.cnt;
            idx_reg <= '0;
        end else if (m_valid && m_ready) begin
            if (at_last) begin
                cnt_reg <= '0;
                idx_reg <= '0;
            end else begin
                idx_reg <= idx_reg + 2'd1;
            end
        end
        if (list_load) begin
            runs_reg <= list_in.runs;
        end
    end

    // The read position never runs past the stored runs.
    `TSPS_ASSERT_IMPL(a_idx_in_range, aclk, aresetn, cnt_reg != 3'd0, {1'b0, idx_reg} < cnt_reg, "read position beyond run list")
    // The list never claims more runs than it stores.
    `TSPS_ASSERT_ALWAYS(a_cnt_bound, aclk, aresetn, cnt_reg <= 3'd4, "run count too large")
    // A list is only loaded when the previous one is done.
    `TSPS_ASSERT_IMPL(a_load_free, aclk, aresetn, list_load, (cnt_reg == 3'd0) || (at_last && m_ready), "run list overwritten")

endmodule

`default_nettype wire

### src/typesetter_stream_page_splitter.sv
// Path: an accepted byte is held in the input register; its runs are then loaded into
// the result register. Throughput: one byte per cycle while each byte makes at most one
// run and m_ready is high; a byte with more runs holds the result register, one run
// per request. A byte that makes no run still passes through the input register.
// Reset: synchronous, active low; clears the stream state and the channels and
// returns page_limit to 100 and skip_inits to 0.
`default_nettype none

module typesetter_stream_page_splitter (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_code_byte,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_out_byte,
    output logic [7:0]       m_repeat_res,
    output logic             m_last
);

    logic [15:0]         page_limit_reg;
    logic [15:0]         skip_inits_reg;
    logic                list_ready;
    logic                list_load;
    tsps_pkg::run_list_t list;

    assign pready = 1'b1;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            page_limit_reg <= tsps_pkg::PAGE_LIMIT_RST;
            skip_inits_reg <= tsps_pkg::SKIP_INITS_RST;
        end else if (psel && penable && pwrite) begin
            case (paddr[2])
                tsps_pkg::REG_PAGE_LIMIT: page_limit_reg <= pwdata[15:0];
                tsps_pkg::REG_SKIP_INITS: skip_inits_reg <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // Register read back.
    always_comb begin
        case (paddr[2])
            tsps_pkg::REG_PAGE_LIMIT: prdata = {16'd0, page_limit_reg};
            tsps_pkg::REG_SKIP_INITS: prdata = {16'd0, skip_inits_reg};
            default:                  prdata = '0;
        endcase
    end

    tsps_step u_step (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_code_byte (s_code_byte),
        .page_limit  (page_limit_reg),
        .skip_inits  (skip_inits_reg),
        .list_ready  (list_ready),
        .list_load   (list_load),
        .list_out    (list)
    );

    tsps_out u_out (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .list_load    (list_load),
        .list_in      (list),
        .list_ready   (list_ready),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_byte   (m_out_byte),
        .m_repeat_res (m_repeat_res),
        .m_last       (m_last)
    );

endmodule

`default_nettype wire
